>>> hw/rtl/bca_pkg.sv
// Shared types and constants of the bitmap contiguous allocator.
package bca_pkg;

  localparam int LEN_W   = 9;
  localparam int BASE_W  = 8;
  localparam int CNT_W   = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_FIT_MODE = 1'b0;

  // fit modes
  localparam logic FIT_FIRST = 1'b0;
  localparam logic FIT_NEXT  = 1'b1;

  typedef struct packed {
    logic accept;      // latch the request transaction
    logic start_clear; // arm the bitmap clearing sweep
    logic start_scan;  // arm a scan for a free run
    logic start_free;  // arm a free sweep
    logic write_step;  // write wr_val at addr, advance
    logic wr_val;
    logic scan_step;   // one scan step
    logic free_step;   // clear one block at pos, advance
    logic res_load;    // load the result registers
    logic res_ok;
    logic res_placed;  // result carries the placed base
  } bca_cmd_t;

  typedef struct packed {
    logic op_free;
    logic len_ok;
    logic cnt_zero;
    logic hit;
    logic scan_end;
    logic free_end;
  } bca_sta_t;

endpackage

>>> hw/rtl/bca_req_if.sv
// Request channel: allocate or free transaction.
interface bca_req_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [bca_pkg::LEN_W-1:0]   run_length;
  logic [bca_pkg::BASE_W-1:0]  run_base;

  modport source (output valid, output opcode, output run_length, output run_base,
                  input ready);
  modport sink   (input valid, input opcode, input run_length, input run_base,
                  output ready);
endinterface

>>> hw/rtl/bca_rsp_if.sv
// Response channel: result of one request transaction.
interface bca_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [bca_pkg::BASE_W-1:0]  placed_base;
  logic [bca_pkg::CNT_W-1:0]   base_sum;
  logic [bca_pkg::CNT_W-1:0]   placed_count;

  modport source (output valid, output ok, output placed_base, output base_sum,
                  output placed_count, input ready);
  modport sink   (input valid, input ok, input placed_base, input base_sum,
                  input placed_count, output ready);
endinterface

>>> hw/rtl/bca_datapath.sv
// Datapath: bitmap memory, scan counters, running totals and result registers.
module bca_datapath #(
  parameter int MEM_BLOCKS = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        fit_mode,
  input  logic                        in_opcode,
  input  logic [bca_pkg::LEN_W-1:0]   in_length,
  input  logic [bca_pkg::BASE_W-1:0]  in_base,
  input  bca_pkg::bca_cmd_t           cmd,
  output bca_pkg::bca_sta_t           sta,
  output logic                        res_ok,
  output logic [bca_pkg::BASE_W-1:0]  res_base,
  output logic [bca_pkg::CNT_W-1:0]   res_sum,
  output logic [bca_pkg::CNT_W-1:0]   res_count
);

  localparam int AW = (MEM_BLOCKS > 1) ? $clog2(MEM_BLOCKS) : 1;
  localparam int CW = AW + 1;
  localparam int PW = (CW > bca_pkg::LEN_W) ? CW : bca_pkg::LEN_W;

  logic                       bitmap [MEM_BLOCKS];
  logic                       mem_q;

  logic                       op_q;
  logic [bca_pkg::LEN_W-1:0]  len_q;
  logic [bca_pkg::BASE_W-1:0] rbase_q;

  logic [AW-1:0]              addr;
  logic [PW-1:0]              pos;
  logic [PW-1:0]              cnt;
  logic                       rd_valid;
  logic [AW-1:0]              rd_addr;
  logic [CW-1:0]              run;
  logic [AW-1:0]              base_q;
  logic [CW-1:0]              next_start;
  logic [bca_pkg::CNT_W-1:0]  base_sum;
  logic [bca_pkg::CNT_W-1:0]  placed_count;

  logic [CW-1:0]              len_c;
  logic [AW-1:0]              scan_start;
  logic [AW-1:0]              addr_inc;
  logic [CW-1:0]              run_from;
  logic [CW-1:0]              run_nx;
  logic [CW-1:0]              hit_sum;
  logic [AW-1:0]              hit_base;
  logic                       hit;
  logic                       rd_en;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;

  assign len_c = CW'(len_q);

  // next fit resumes after the last run; a run ending at the top restarts at zero
  always_comb begin
    scan_start = '0;
    if (fit_mode == bca_pkg::FIT_NEXT && next_start != CW'(MEM_BLOCKS)) begin
      scan_start = next_start[AW-1:0];
    end
  end

  assign addr_inc = (addr == AW'(MEM_BLOCKS - 1)) ? '0 : addr + 1'b1;

  // the run restarts at block zero so it never wraps
  assign run_from = (rd_addr == '0) ? '0 : run;
  assign run_nx   = mem_q ? '0 : run_from + 1'b1;
  assign hit      = cmd.scan_step && rd_valid && !mem_q && (run_nx == len_c);
  assign hit_sum  = CW'(rd_addr) + CW'(1) - len_c;
  assign hit_base = hit_sum[AW-1:0];

  assign rd_en   = cmd.scan_step && (cnt != '0);
  assign wr_en   = cmd.write_step || cmd.free_step;
  assign wr_addr = cmd.free_step ? pos[AW-1:0] : addr;

  assign sta.op_free  = (op_q == bca_pkg::OP_FREE);
  assign sta.len_ok   = (len_q != '0) && (PW'(len_q) <= PW'(MEM_BLOCKS));
  assign sta.cnt_zero = (cnt == '0);
  assign sta.hit      = hit;
  assign sta.scan_end = cmd.scan_step && !rd_valid && (cnt == '0);
  assign sta.free_end = (cnt == '0) || (pos >= PW'(MEM_BLOCKS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap[wr_addr] <= cmd.wr_val;
    end
    if (rd_en) begin
      mem_q <= bitmap[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid     <= 1'b0;
      base_sum     <= '0;
      placed_count <= '0;
      next_start   <= '0;
    end else begin
      if (cmd.start_scan) begin
        rd_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_valid <= rd_en;
      end
      if (hit) begin
        base_sum     <= base_sum + bca_pkg::CNT_W'(hit_base);
        placed_count <= placed_count + 1'b1;
        if (fit_mode == bca_pkg::FIT_NEXT) begin
          next_start <= CW'(hit_base) + len_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= in_opcode;
      len_q   <= in_length;
      rbase_q <= in_base;
    end
    if (cmd.start_clear) begin
      addr <= '0;
      cnt  <= PW'(MEM_BLOCKS);
    end
    if (cmd.start_scan) begin
      addr <= scan_start;
      cnt  <= PW'(MEM_BLOCKS);
      run  <= '0;
    end
    if (cmd.start_free) begin
      pos <= PW'(rbase_q);
      cnt <= PW'(len_q);
    end
    if (cmd.write_step) begin
      addr <= addr_inc;
      cnt  <= cnt - 1'b1;
    end
    if (cmd.free_step) begin
      pos <= pos + 1'b1;
      cnt <= cnt - 1'b1;
    end
    if (cmd.scan_step) begin
      if (rd_valid) begin
        run <= run_nx;
      end
      // found: rewind to the base for the marking sweep
      if (hit) begin
        base_q <= hit_base;
        addr   <= hit_base;
        cnt    <= PW'(len_c);
      end else if (rd_en) begin
        addr    <= addr_inc;
        cnt     <= cnt - 1'b1;
        rd_addr <= addr;
      end
    end
    if (cmd.res_load) begin
      res_ok    <= cmd.res_ok;
      res_base  <= cmd.res_placed ? bca_pkg::BASE_W'(base_q) : '0;
      res_sum   <= base_sum;
      res_count <= placed_count;
    end
  end

endmodule

>>> hw/rtl/bca_ctrl.sv
// Controller: sequences clearing, scanning, marking and freeing.
module bca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bca_pkg::bca_sta_t sta,
  output bca_pkg::bca_cmd_t cmd
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_CLEAR    = 3'd1;
  localparam logic [2:0] S_IDLE     = 3'd2;
  localparam logic [2:0] S_DISPATCH = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_MARK     = 3'd5;
  localparam logic [2:0] S_FREE     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.start_clear = 1'b1;
        state_next      = S_CLEAR;
      end
      S_CLEAR: begin
        if (sta.cnt_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.write_step = 1'b1;
          cmd.wr_val     = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sta.op_free) begin
          cmd.start_free = 1'b1;
          state_next     = S_FREE;
        end else if (sta.len_ok) begin
          cmd.start_scan = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sta.hit) begin
          state_next = S_MARK;
        end else if (sta.scan_end) begin
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_MARK: begin
        if (sta.cnt_zero) begin
          cmd.res_load   = 1'b1;
          cmd.res_ok     = 1'b1;
          cmd.res_placed = 1'b1;
          state_next     = S_DONE;
        end else begin
          cmd.write_step = 1'b1;
          cmd.wr_val     = 1'b1;
        end
      end
      S_FREE: begin
        if (sta.free_end) begin
          cmd.res_load = 1'b1;
          cmd.res_ok   = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.free_step = 1'b1;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/bitmap_contiguous_allocator.sv
// Top level of the bitmap contiguous allocator.
//
// Contiguous run allocator over an occupancy bitmap of MEM_BLOCKS unit
// blocks, one bit per block in a single-port memory. An allocate transaction
// asks for run_length free blocks in a row; fit_mode selects first fit
// (lowest run) or next fit (search from the end of the last placement to the
// top, then from block zero up to that point, never wrapping a run). On
// success the run is marked, the base is added to base_sum, placed_count
// increments and the base comes back in placed_base. A free transaction
// clears run_length blocks from run_base, clipped at the top of memory, and
// always reports ok. One transaction is in flight at a time. Timing is set
// by the bitmap memory, which is visited one block per cycle: an allocate is
// dispatched, scans for a free run and, if one is found, marks it before the
// response is offered; a free clears its blocks one at a time from run_base;
// a rejected allocate goes straight to the response. After reset a clearing
// pass over all MEM_BLOCKS blocks runs before the first request is accepted;
// configuration writes are taken at any time.
module bitmap_contiguous_allocator #(
  parameter int MEM_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  bca_req_if.sink                       req,
  bca_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bca_pkg::ADDR_W-1:0]    paddr,
  input  logic [bca_pkg::DATA_W-1:0]    pwdata,
  output logic [bca_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic              fit_mode;
  logic              cfg_wr;
  bca_pkg::bca_cmd_t cmd;
  bca_pkg::bca_sta_t sta;

  // APB: zero wait states; register index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= bca_pkg::FIT_FIRST;
    end else if (cfg_wr && paddr[2] == bca_pkg::REG_FIT_MODE) begin
      fit_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bca_pkg::REG_FIT_MODE) begin
      prdata[0] = fit_mode;
    end
  end

  bca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sta       (sta),
    .cmd       (cmd)
  );

  // result registers double as the response payload
  bca_datapath #(
    .MEM_BLOCKS (MEM_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .fit_mode  (fit_mode),
    .in_opcode (req.opcode),
    .in_length (req.run_length),
    .in_base   (req.run_base),
    .cmd       (cmd),
    .sta       (sta),
    .res_ok    (rsp.ok),
    .res_base  (rsp.placed_base),
    .res_sum   (rsp.base_sum),
    .res_count (rsp.placed_count)
  );

`ifndef SYNTHESIS
  // never take a request while a response is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("request accepted while response pending");

  // an accepted request leaves the idle state
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second request accepted while busy");

  // a failed allocate reports base zero
  a_fail_base: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ok) |-> (rsp.placed_base == '0))
    else $error("nonzero base on failed allocate");

  // response is offered only after a request was taken
  a_rsp_after_req: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> !req.ready)
    else $error("response raised while idle");
`endif

endmodule
